/* rtl/qsort_pkg.sv */
// ----------------------------------------------------------------------------
// qsort_pkg
// Shared constants for the quicksort unit and its storage.
// ----------------------------------------------------------------------------
`default_nettype none

package qsort_pkg;

  // default capacity of the element store
  localparam int unsigned MAX_ITEMS_DEF = 64;

  // width of one element
  localparam int unsigned DATA_W = 32;

endpackage

`default_nettype wire

/* rtl/qsort_ram.sv */
// ----------------------------------------------------------------------------
// qsort_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module qsort_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

/* rtl/quicksort_hoare_middle_pivot_unit.sv */
// Operation: items are loaded while idle; after the item marked last the set is
// sorted in place through the element memory, then results leave one at a time
// under the output handshake.
// Throughput: one set at a time; no new item is taken until the set is out.
// Reset: asynchronous, clears count, stack pointer, drop flag and control;
// element and range memories are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// quicksort_hoare_middle_pivot_unit
// Collects signed values, sorts them by quicksort with Hoare partitioning
// around the middle element using an explicit range stack, then streams
// them out in ascending order.
// ----------------------------------------------------------------------------
`default_nettype none

module quicksort_hoare_middle_pivot_unit
  import qsort_pkg::*;
#(
  parameter int unsigned MAX_ITEMS = MAX_ITEMS_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // input items
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire logic [DATA_W-1:0] s_axis_tdata,   // [31:0] value
  input  wire logic              s_axis_tlast,
  // result items
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output logic      [DATA_W-1:0] m_axis_tdata,   // [31:0] sorted_value
  output logic                   m_axis_tlast,
  output logic                   m_axis_tuser    // [0] overflowed
);

  localparam int unsigned IW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int unsigned CW = $clog2(MAX_ITEMS + 1);
  localparam int unsigned SW = 2 * IW;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INIT,
    S_POP,
    S_POPW,
    S_PIV,
    S_LOOP,
    S_SCI,
    S_SCJ,
    S_SWAP,
    S_PUSH1,
    S_PUSH2,
    S_OLOAD,
    S_OWAIT
  } state_e;

  state_e state_q, state_d;

  logic [CW-1:0]     cnt_q, cnt_d;
  logic              drop_q, drop_d;
  logic [CW-1:0]     sp_q, sp_d;
  logic [IW-1:0]     lo_q, lo_d;
  logic [IW-1:0]     hi_q, hi_d;
  logic [CW-1:0]     i_q, i_d;
  logic [CW-1:0]     jp_q, jp_d;     // one above the right scan index
  logic [DATA_W-1:0] piv_q, piv_d;
  logic [DATA_W-1:0] vi_q, vi_d;
  logic [CW-1:0]     k_q, k_d;
  logic [DATA_W-1:0] out_data_q, out_data_d;
  logic              out_last_q, out_last_d;
  logic              out_user_q, out_user_d;
  logic              out_valid_q, out_valid_d;

  // memory ports
  logic              st_we;
  logic [IW-1:0]     st_waddr;
  logic [DATA_W-1:0] st_wdata;
  logic [IW-1:0]     st_raddr;
  logic [DATA_W-1:0] st_rdata;
  logic              sk_we;
  logic [IW-1:0]     sk_waddr;
  logic [SW-1:0]     sk_wdata;
  logic [IW-1:0]     sk_raddr;
  logic [SW-1:0]     sk_rdata;

  // index arithmetic
  logic [CW-1:0]     cnt_inc, cnt_dec, sp_dec, i_inc, jp_dec, jp_dec2, k_inc;
  logic [CW-1:0]     lo_ext, hi_ext, hi_inc;
  logic [IW-1:0]     pop_lo, pop_hi, pop_mid, pop_span;
  logic [CW:0]       two_p, lo_hi_sum;
  logic              left_first, left_ok, right_ok, push_ok;
  logic [SW-1:0]     left_ent, right_ent;
  logic              elem_lt, elem_gt;

  qsort_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ITEMS)) u_elem_ram (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  qsort_ram #(.WIDTH(SW), .DEPTH(MAX_ITEMS)) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (sk_we),
    .waddr_i (sk_waddr),
    .wdata_i (sk_wdata),
    .raddr_i (sk_raddr),
    .rdata_o (sk_rdata)
  );

  // p - 1 as an element index
  function automatic logic [IW-1:0] jp_dec_lo(input logic [CW-1:0] p);
    logic [CW-1:0] pm;
    pm = p - CW'(1);
    return pm[IW-1:0];
  endfunction

  // shared index adders and the element comparators
  always_comb begin
    cnt_inc   = cnt_q + CW'(1);
    cnt_dec   = cnt_q - CW'(1);
    sp_dec    = sp_q - CW'(1);
    i_inc     = i_q + CW'(1);
    jp_dec    = jp_q - CW'(1);
    jp_dec2   = jp_q - CW'(2);
    k_inc     = k_q + CW'(1);
    lo_ext    = CW'(lo_q);
    hi_ext    = CW'(hi_q);
    hi_inc    = hi_ext + CW'(1);
    pop_lo    = sk_rdata[SW-1:IW];
    pop_hi    = sk_rdata[IW-1:0];
    pop_span  = pop_hi - pop_lo;
    pop_mid   = pop_lo + (pop_span >> 1);
    // left part larger when p - 1 - lo > hi - p
    two_p     = {1'b0, i_q} + {1'b0, i_q};
    lo_hi_sum = (CW+1)'(lo_q) + (CW+1)'(hi_q) + (CW+1)'(1);
    left_first = two_p > lo_hi_sum;
    left_ok   = (lo_ext + CW'(1)) < i_q;
    right_ok  = i_q < hi_ext;
    push_ok   = sp_q < CW'(MAX_ITEMS);
    left_ent  = {lo_q, jp_dec_lo(i_q)};
    right_ent = {i_q[IW-1:0], hi_q};
    elem_lt   = $signed(st_rdata) < $signed(piv_q);
    elem_gt   = $signed(st_rdata) > $signed(piv_q);
  end

  // sequencer next state
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    drop_d      = drop_q;
    sp_d        = sp_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    i_d         = i_q;
    jp_d        = jp_q;
    piv_d       = piv_q;
    vi_d        = vi_q;
    k_d         = k_q;
    out_data_d  = out_data_q;
    out_last_d  = out_last_q;
    out_user_d  = out_user_q;
    out_valid_d = out_valid_q;
    st_we       = 1'b0;
    st_waddr    = '0;
    st_wdata    = s_axis_tdata;
    st_raddr    = '0;
    sk_we       = 1'b0;
    sk_waddr    = '0;
    sk_wdata    = '0;
    sk_raddr    = '0;

    unique case (state_q)
      // load items, drop those beyond capacity
      S_IDLE: begin
        if (s_axis_tvalid) begin
          if (cnt_q < CW'(MAX_ITEMS)) begin
            st_we    = 1'b1;
            st_waddr = cnt_q[IW-1:0];
            cnt_d    = cnt_inc;
          end else begin
            drop_d = 1'b1;
          end
          if (s_axis_tlast) begin
            state_d = S_INIT;
          end
        end
      end
      // push the whole range when it holds two or more items
      S_INIT: begin
        sp_d = '0;
        if (cnt_q >= CW'(2)) begin
          sk_we    = 1'b1;
          sk_waddr = '0;
          sk_wdata = {{IW{1'b0}}, cnt_dec[IW-1:0]};
          sp_d     = CW'(1);
        end
        state_d = S_POP;
      end
      // pop a range or start output
      S_POP: begin
        if (sp_q == '0) begin
          k_d      = '0;
          st_raddr = '0;
          state_d  = S_OLOAD;
        end else begin
          sp_d     = sp_dec;
          sk_raddr = sp_dec[IW-1:0];
          state_d  = S_POPW;
        end
      end
      // check range, fetch the middle element
      S_POPW: begin
        lo_d = pop_lo;
        hi_d = pop_hi;
        if (pop_lo >= pop_hi || CW'(pop_hi) >= cnt_q) begin
          state_d = S_POP;
        end else begin
          st_raddr = pop_mid;
          state_d  = S_PIV;
        end
      end
      S_PIV: begin
        piv_d   = st_rdata;
        i_d     = lo_ext;
        jp_d    = hi_inc;
        state_d = S_LOOP;
      end
      // partition loop head
      S_LOOP: begin
        if (i_q < jp_q) begin
          st_raddr = i_q[IW-1:0];
          state_d  = S_SCI;
        end else begin
          state_d = S_PUSH1;
        end
      end
      // left scan: skip elements below the pivot
      S_SCI: begin
        if (elem_lt) begin
          i_d      = i_inc;
          st_raddr = i_inc[IW-1:0];
        end else begin
          vi_d     = st_rdata;
          st_raddr = jp_dec[IW-1:0];
          state_d  = S_SCJ;
        end
      end
      // right scan: skip elements above the pivot
      S_SCJ: begin
        if (elem_gt) begin
          jp_d     = jp_dec;
          st_raddr = jp_dec2[IW-1:0];
        end else if (i_q < jp_q) begin
          st_we    = 1'b1;
          st_waddr = i_q[IW-1:0];
          st_wdata = st_rdata;
          state_d  = S_SWAP;
        end else begin
          state_d = S_LOOP;
        end
      end
      // second half of the swap
      S_SWAP: begin
        st_we    = 1'b1;
        st_waddr = jp_dec[IW-1:0];
        st_wdata = vi_q;
        i_d      = i_inc;
        jp_d     = jp_dec;
        state_d  = S_LOOP;
      end
      // push the larger part first
      S_PUSH1: begin
        if (left_first ? left_ok : right_ok) begin
          if (push_ok) begin
            sk_we    = 1'b1;
            sk_waddr = sp_q[IW-1:0];
            sk_wdata = left_first ? left_ent : right_ent;
            sp_d     = sp_q + CW'(1);
          end
        end
        state_d = S_PUSH2;
      end
      S_PUSH2: begin
        if (left_first ? right_ok : left_ok) begin
          if (push_ok) begin
            sk_we    = 1'b1;
            sk_waddr = sp_q[IW-1:0];
            sk_wdata = left_first ? right_ent : left_ent;
            sp_d     = sp_q + CW'(1);
          end
        end
        state_d = S_POP;
      end
      // capture the next sorted element
      S_OLOAD: begin
        out_data_d  = st_rdata;
        out_last_d  = (k_inc == cnt_q);
        out_user_d  = drop_q;
        out_valid_d = 1'b1;
        state_d     = S_OWAIT;
      end
      S_OWAIT: begin
        if (m_axis_tready) begin
          out_valid_d = 1'b0;
          if (out_last_q) begin
            cnt_d   = '0;
            drop_d  = 1'b0;
            sp_d    = '0;
            state_d = S_IDLE;
          end else begin
            k_d      = k_inc;
            st_raddr = k_inc[IW-1:0];
            state_d  = S_OLOAD;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state, counters and the output valid register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      drop_q      <= 1'b0;
      sp_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      drop_q      <= drop_d;
      sp_q        <= sp_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    i_q        <= i_d;
    jp_q       <= jp_d;
    piv_q      <= piv_d;
    vi_q       <= vi_d;
    k_q        <= k_d;
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
    out_user_q <= out_user_d;
  end

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_user_q;

`ifndef SYNTHESIS
  // element count never passes capacity
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MAX_ITEMS))
    else $error("element count above capacity");

  // range stack never passes its depth
  a_sp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= CW'(MAX_ITEMS))
    else $error("range stack overflow");

  // left scan stays inside the store
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCI) |-> (i_q < CW'(MAX_ITEMS)))
    else $error("left scan out of range");

  // input and output never open together
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !m_axis_tvalid)
    else $error("input ready while a result is pending");

  // the final result empties the unit
  a_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast)
      |=> (cnt_q == '0 && !drop_q && state_q == S_IDLE))
    else $error("state not cleared after end of set");
`endif

endmodule

`default_nettype wire
